/* rtl/plcst_pkg.sv */
// ----------------------------------------------------------------------------
// plcst_pkg: shared types and constants for the PLC-style timer
// Mode codes, field widths and the configuration record.
// ----------------------------------------------------------------------------
`default_nettype none

package plcst_pkg;

  // Time base width; the elapsed count wraps modulo 2^TIME_WIDTH
  localparam int TIME_WIDTH = 32;
  // Widths of the fixed fields
  localparam int NOW_W      = 32;
  localparam int PRESET_W   = 32;
  localparam int MODE_W     = 3;
  // Compare width covers both the elapsed count and the preset
  localparam int CMP_W      = (TIME_WIDTH > PRESET_W) ? TIME_WIDTH : PRESET_W;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMER_MODE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESET_TICKS = 1'd1;
  localparam int CFG_DATA_W = 32;

  // Timer modes
  localparam logic [MODE_W-1:0] MODE_PULSE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXT_PULSE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RET_ON    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OFF_DELAY = 3'd4;

  // Configuration as seen by the timer core
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PRESET_W-1:0] preset;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/plcst_cfg_regs.sv */
// ----------------------------------------------------------------------------
// plcst_cfg_regs: configuration registers
// Holds the timer mode and preset, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module plcst_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [plcst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [plcst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output plcst_pkg::cfg_t                        cfg
);
  import plcst_pkg::*;

  logic [MODE_W-1:0]   timer_mode;
  logic [PRESET_W-1:0] preset_ticks;

  // Register writes; only the low bits of the mode field are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode   <= MODE_PULSE;
      preset_ticks <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIMER_MODE:   timer_mode   <= cfg_wdata[MODE_W-1:0];
        REG_PRESET_TICKS: preset_ticks <= cfg_wdata[PRESET_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.mode   = timer_mode;
  assign cfg.preset = preset_ticks;

endmodule

`default_nettype wire

/* rtl/plcst_core.sv */
// ----------------------------------------------------------------------------
// plcst_core: timer state and evaluation
// Keeps the running flag and start timestamp, and works out the output bit
// of each accepted request from one wrapping subtract and one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module plcst_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic                        set_level,
  input  wire logic                        reset_level,
  input  wire logic [plcst_pkg::NOW_W-1:0] now_ticks,
  input  wire plcst_pkg::cfg_t             cfg,
  output logic                             q
);
  import plcst_pkg::*;

  logic                  running;
  logic                  running_next;
  logic [TIME_WIDTH-1:0] start_time;
  logic [TIME_WIDTH-1:0] start_time_next;

  logic [CMP_W-1:0]      now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  start;
  logic                  run1;
  logic                  live;

  // Time base fitted to TIME_WIDTH: truncated or zero-extended
  assign now_ext = CMP_W'(now_ticks);
  assign now_t   = now_ext[TIME_WIDTH-1:0];

  // Start (or restart in off-delay) when set is high
  assign start   = set_level && ((cfg.mode == MODE_OFF_DELAY) || !running);
  assign run1    = start || running;
  assign start_time_next = start ? now_t : start_time;
  assign elapsed = now_t - start_time_next;
  assign live    = CMP_W'(elapsed) < CMP_W'(cfg.preset);

  // Per-mode output and flag update
  always_comb begin
    q            = 1'b0;
    running_next = running;
    if (cfg.mode > MODE_OFF_DELAY) begin
      q            = 1'b0;
      running_next = running;
    end else if (reset_level || ((cfg.mode == MODE_PULSE) && !set_level)) begin
      running_next = 1'b0;
    end else begin
      running_next = run1;
      case (cfg.mode)
        MODE_PULSE: q = live;
        MODE_EXT_PULSE: begin
          if (live) begin
            q = 1'b1;
          end else if (!set_level) begin
            running_next = 1'b0;
          end
        end
        MODE_ON_DELAY: begin
          if (!live) begin
            running_next = set_level && run1;
            q            = set_level && run1;
          end
        end
        MODE_RET_ON: begin
          if (!live) q = run1;
        end
        default: begin
          if (live) begin
            q = run1;
          end else begin
            running_next = 1'b0;
          end
        end
      endcase
    end
  end

  // State registers; start time only changes on a real start
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      start_time <= '0;
    end else if (accept) begin
      running <= running_next;
      if (start && (cfg.mode <= MODE_OFF_DELAY) && !reset_level &&
          !((cfg.mode == MODE_PULSE) && !set_level)) begin
        start_time <= start_time_next;
      end
    end
  end

  // Reset input in a defined mode always leaves the timer idle
  a_reset_idles: assert property (@(posedge clk) disable iff (rst)
    accept && reset_level && (cfg.mode <= MODE_OFF_DELAY) |=> !running)
    else $error("running set after reset_level request");

  // Undefined modes leave the state alone
  a_bad_mode_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (cfg.mode > MODE_OFF_DELAY) |=> $stable(running) && $stable(start_time))
    else $error("state changed in undefined mode");

  // Outside extended pulse a high output means the timer is running
  a_out_running: assert property (@(posedge clk) disable iff (rst)
    accept && q && (cfg.mode != MODE_EXT_PULSE) |=> running)
    else $error("output high with timer stopped");

endmodule

`default_nettype wire

/* rtl/plcst_out_reg.sv */
// ----------------------------------------------------------------------------
// plcst_out_reg: result register
// Holds one result until the receiver takes it; a new request can be
// accepted in the same cycle that the held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module plcst_out_reg (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire logic q,
  output logic      can_load,
  output logic      out_valid,
  output logic      out_q,
  input  wire logic out_ready
);

  // Free when empty or being drained this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) out_q <= q;
  end

endmodule

`default_nettype wire

/* rtl/plc_style_timer.sv */
// ----------------------------------------------------------------------------
// plc_style_timer: PLC-style timer with five modes
// Pulse, extended pulse, on-delay, retentive on-delay and off-delay timer
// evaluated once per stream request.
//
// Input stream (s_*): each request carries set and reset levels and the
// current value of a free-running time base. Output stream (m_*): one
// timer output bit per request, in order.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata, index 0 is the mode,
// index 1 the preset in ticks. Write only while the block is idle.
// Output: the result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while m_tready is high; the state update is one wrapping
// subtract and one compare on the time base, done in the accepting cycle.
// Reset (rst, synchronous): running flag, start time and configuration
// clear, the output register empties.
// Stall: while m_tready is low the held result stays and s_tready drops;
// a request is taken in the same cycle that the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_style_timer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [0] set_level, [1] reset_level, [33:2] now_ticks, [39:34] zero
  input  wire logic [plcst_pkg::IN_DATA_W-1:0]   s_tdata,
  // Result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] timer_out, [7:1] zero
  output logic [plcst_pkg::OUT_DATA_W-1:0]       m_tdata,
  // Configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [plcst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [plcst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import plcst_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic             q;
  logic             out_q;
  logic [NOW_W-1:0] now_ticks;

  assign now_ticks = s_tdata[NOW_W+1:2];
  assign accept    = s_tvalid && s_tready;

  plcst_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  plcst_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .set_level   (s_tdata[0]),
    .reset_level (s_tdata[1]),
    .now_ticks   (now_ticks),
    .cfg         (cfg),
    .q           (q)
  );

  plcst_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s_tvalid),
    .q         (q),
    .can_load  (s_tready),
    .out_valid (m_tvalid),
    .out_q     (out_q),
    .out_ready (m_tready)
  );

  assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, out_q};

endmodule

`default_nettype wire

/* bench/tb_plc_style_timer.sv */
// ----------------------------------------------------------------------------
// tb_plc_style_timer: self-checking bench for the PLC-style timer
// Drives timer evaluations (set, reset, time stamp) over the request stream
// under all mode codes and a range of presets. A local timer model predicts
// each output bit, and a checker compares every result in order. Both stream
// sides idle at random; one phase holds the result side off to fill the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_plc_style_timer;
  import plcst_pkg::*;

  // Mode codes above off-delay have no function assigned
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_MAX     = 3'd7;
  localparam logic [PRESET_W-1:0] PRESET_MAX      = '1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT    = 18;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Timer model state and its copy of the registers
  logic                   timer_running = 1'b0;
  logic [TIME_WIDTH-1:0]  timer_start = '0;
  logic [MODE_W-1:0]      cfg_mode = '0;
  logic [PRESET_W-1:0]    cfg_preset = '0;

  // Output bits predicted for accepted requests, oldest first
  logic                   pending_outputs[$];

  // Stimulus state shared by the test tasks
  logic [NOW_W-1:0]       stamp_now = '0;
  logic                   set_run = 1'b0;
  bit                     idle_en = 1'b1;
  int                     hold_request = 0;
  int                     hold_left = 0;

  int                     mismatches = 0;
  int                     requests_sent = 0;
  int                     results_seen = 0;
  int                     settings_applied = 0;
  int                     cycle_count = 0;

  plc_style_timer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outputs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Timer model: one evaluation, updates running flag and start time
  function automatic logic timer_predict(input logic set_l, input logic rst_l,
                                         input logic [NOW_W-1:0] now);
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  live;
    logic                  q;
    now_t = now;
    q = 1'b0;
    if (cfg_mode > MODE_OFF_DELAY) return 1'b0;
    if (rst_l || (cfg_mode == MODE_PULSE && !set_l)) begin
      timer_running = 1'b0;
      return 1'b0;
    end
    if (set_l && (cfg_mode == MODE_OFF_DELAY || !timer_running)) begin
      timer_running = 1'b1;
      timer_start = now_t;
    end
    // wrapping elapsed count, compared against the stored start even if idle
    elapsed = now_t - timer_start;
    live = (CMP_W'(elapsed) < CMP_W'(cfg_preset));
    case (cfg_mode)
      MODE_PULSE: begin
        q = live;
      end
      MODE_EXT_PULSE: begin
        if (live) q = 1'b1;
        else if (!set_l) timer_running = 1'b0;
      end
      MODE_ON_DELAY: begin
        if (!live) begin
          if (!set_l) timer_running = 1'b0;
          q = timer_running;
        end
      end
      MODE_RET_ON: begin
        if (!live) q = timer_running;
      end
      default: begin
        if (live) q = timer_running;
        else timer_running = 1'b0;
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("MISMATCH %s: got %0b, expected %0b (result %0d)", what, got, want,
             results_seen);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    logic want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("result with no request pending", m_tdata[0], 1'b0);
      end else begin
        want = pending_outputs.pop_front();
        if (m_tdata[0] !== want) report_mismatch("timer_out", m_tdata[0], want);
        if (m_tdata[OUT_DATA_W-1:1] !== '0)
          report_mismatch("pad bits", |m_tdata[OUT_DATA_W-1:1], 1'b0);
      end
      results_seen++;
    end
  end

  // Result side ready: random idling, plus long holds on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (idle_en) begin
      m_tready = ($urandom_range(99) >= IDLE_PCT);
    end else begin
      m_tready = 1'b1;
    end
  end

  // Send one request; returns at the accepting edge with tvalid still high
  task automatic send_request(input logic set_l, input logic rst_l,
                              input logic [NOW_W-1:0] now);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {{(IN_DATA_W-NOW_W-2){1'b0}}, now, rst_l, set_l};
    do @(posedge clk); while (!s_tready);
    pending_outputs.push_back(timer_predict(set_l, rst_l, now));
    requests_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // One register write; leaves the write enable high
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    if (idx == REG_TIMER_MODE) cfg_mode = val[MODE_W-1:0];
    else cfg_preset = val[PRESET_W-1:0];
  endtask

  // New mode and preset, written only once the block has gone idle
  task automatic apply_setting(input logic [MODE_W-1:0] mode,
                               input logic [PRESET_W-1:0] preset);
    logic [CFG_DATA_W-1:0] mode_word;
    drain_results();
    // upper bits of the mode word are don't-care
    mode_word = $urandom();
    mode_word[MODE_W-1:0] = mode;
    write_reg(REG_TIMER_MODE, mode_word);
    write_reg(REG_PRESET_TICKS, preset);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    settings_applied++;
  endtask

  // Run of evaluations on an advancing time base, set held in runs,
  // stamps often aimed at the expiry edge, with some noise
  task automatic send_random_run(input int n);
    int                r;
    logic              rst_l;
    logic [NOW_W-1:0]  step_max;
    step_max = (cfg_preset < 16) ? 4 : (cfg_preset >> 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) set_run = ~set_run;
      rst_l = ($urandom_range(99) < 5);
      r = $urandom_range(99);
      if (r < 72) stamp_now = stamp_now + $urandom_range(0, step_max);
      else if (r < 88) stamp_now = timer_start + cfg_preset - 1 + $urandom_range(0, 2);
      else if (r < 94) stamp_now = $urandom();
      if ($urandom_range(99) < 4) begin
        set_run = 1'($urandom_range(1));
        rst_l = 1'($urandom_range(1));
      end
      send_request(set_run, rst_l, stamp_now);
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  // Directed walk through each mode, reset, zero and maximum preset,
  // unassigned mode codes and time base wrap
  task automatic test_directed();
    apply_setting(MODE_PULSE, 5);
    send_request(1'b1, 1'b0, 32'hFFFF_FFFE);
    send_request(1'b1, 1'b0, 32'h0000_0002);
    send_request(1'b1, 1'b0, 32'h0000_0003);
    send_request(1'b0, 1'b0, 32'h0000_0004);
    apply_setting(MODE_EXT_PULSE, 3);
    send_request(1'b1, 1'b0, 32'd100);
    send_request(1'b0, 1'b0, 32'd102);
    send_request(1'b0, 1'b0, 32'd103);
    send_request(1'b1, 1'b1, 32'd104);
    apply_setting(MODE_ON_DELAY, 3);
    send_request(1'b1, 1'b0, 32'd10);
    send_request(1'b1, 1'b0, 32'd13);
    send_request(1'b0, 1'b0, 32'd14);
    apply_setting(MODE_RET_ON, 4);
    send_request(1'b1, 1'b0, 32'd20);
    send_request(1'b0, 1'b0, 32'd24);
    send_request(1'b0, 1'b1, 32'd25);
    apply_setting(MODE_OFF_DELAY, 4);
    send_request(1'b1, 1'b0, 32'd30);
    send_request(1'b0, 1'b0, 32'd33);
    send_request(1'b0, 1'b0, 32'd34);
    // zero preset: already expired on start
    apply_setting(MODE_ON_DELAY, 0);
    send_request(1'b1, 1'b0, 32'h0000_0000);
    send_request(1'b1, 1'b0, 32'hFFFF_FFFF);
    // unassigned mode codes give zero and keep state
    apply_setting(MODE_UNUSED_FIRST, PRESET_MAX);
    send_request(1'b1, 1'b0, 32'h0000_0000);
    apply_setting(MODE_CODE_MAX, PRESET_MAX);
    send_request(1'b1, 1'b1, 32'hFFFF_FFFF);
    apply_setting(MODE_PULSE, PRESET_MAX);
    send_request(1'b1, 1'b0, 32'h8000_0000);
    send_request(1'b1, 1'b0, 32'h7FFF_FFFE);
  endtask

  // Many settings, random runs under each
  task automatic test_random_settings();
    logic [MODE_W-1:0]   mode;
    logic [PRESET_W-1:0] preset;
    int                  r;
    for (int p = 0; p < 28; p++) begin
      if ($urandom_range(99) < 12)
        mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_CODE_MAX));
      else mode = MODE_W'($urandom_range(MODE_PULSE, MODE_OFF_DELAY));
      r = $urandom_range(99);
      if (r < 10) preset = '0;
      else if (r < 20) preset = 1;
      else if (r < 30) preset = PRESET_MAX;
      else if (r < 42) preset = $urandom();
      else preset = $urandom_range(2, 40);
      apply_setting(mode, preset);
      // now and then start close to the wrap point
      if (p % 7 == 3) stamp_now = '1 - $urandom_range(0, 60);
      else if (p % 7 == 5) stamp_now = $urandom();
      send_random_run(60);
    end
  endtask

  // Long stretch with no idling on either side
  task automatic test_steady_stream();
    drain_results();
    idle_en = 1'b0;
    apply_setting(MODE_OFF_DELAY, 12);
    send_random_run(75);
    apply_setting(MODE_EXT_PULSE, 9);
    send_random_run(75);
    drain_results();
    idle_en = 1'b1;
  endtask

  // Result side held off while requests keep coming, block must stall input
  task automatic test_backpressure();
    apply_setting(MODE_ON_DELAY, 8);
    @(negedge clk);
    hold_request = 200;
    send_random_run(30);
    drain_results();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_settings();
    test_steady_stream();
    test_backpressure();
    drain_results();
    repeat (4) @(negedge clk);
    while (pending_outputs.size() != 0) begin
      report_mismatch("result never arrived", 1'b0, pending_outputs.pop_front());
    end
    $display("Covered %0d timer evaluations under %0d mode/preset settings, all mode codes",
             requests_sent, settings_applied);
    $display("Checked %0d results in order, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
